>>> sv/sacft_pkg.sv
// Shared constants, types and helpers for the cache tag store.
`default_nettype none
package sacft_pkg;

    localparam int SETS    = 64;   // power of two
    localparam int WAYS    = 4;
    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 61;
    localparam int SHIFT_W = 4;
    localparam int REQ_W   = 3;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [SET_W-1:0]   SET_MASK    = SET_W'(SETS - 1);
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(6);
    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = SHIFT_W'(3);
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = SHIFT_W'(12);

    localparam logic [REQ_W-1:0] REQ_READ  = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_WRITE = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_CLEAN = REQ_W'(2);
    localparam logic [REQ_W-1:0] REQ_INV   = REQ_W'(3);
    localparam logic [REQ_W-1:0] REQ_CINV  = REQ_W'(4);

    typedef struct packed {
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } t_way;

    typedef struct packed {
        logic [WAY_W-1:0]  vptr;
        logic [WAYS-1:0]   valid;
        t_way [WAYS-1:0]   ways;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
    } t_split;

    typedef struct packed {
        logic              hit;
        logic              wb_valid;
        logic [ADDR_W-1:0] wb_addr;
        logic              rf_valid;
        logic [ADDR_W-1:0] rf_addr;
        logic              cleaned;
    } t_result;

    // line address back to a line-aligned byte address
    function automatic logic [ADDR_W-1:0] line_to_addr(input logic [TAG_W-1:0] tag,
                                                       input logic [SHIFT_W-1:0] sh);
        logic [ADDR_W-1:0] w;
        w = ADDR_W'(tag);
        return w << sh;
    endfunction

endpackage
`default_nettype wire

>>> sv/set_assoc_cache_fifo_tags.sv
// Top level: tag store of a write-back set-associative cache, FIFO replacement.
//
//  channel   handshake               payload
//  request   start (busy held low)   i_req_type, i_address
//  result    o_valid strobe          o_hit, o_writeback_*, o_refill_*, o_line_cleaned
//  config    i_cfg_we                i_cfg_wdata (line_shift)
//
// One transaction per cycle; each result reaches the ports after the set row is read from the
// tag RAM into its registered read data, then compare/update is written into the result register.
// A write to the row of the previous transaction is forwarded to the next one.
// Synchronous active-low reset clears set-init bits and pipeline flags, resets line_shift to 6; a set not yet
// written reads as empty with its pointer at way 0.
// The receiver cannot stall; busy is always low.
`default_nettype none
module set_assoc_cache_fifo_tags
    import sacft_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [REQ_W-1:0]   i_req_type,
    input  wire logic [ADDR_W-1:0]  i_address,
    input  wire logic               i_cfg_we,
    input  wire logic [SHIFT_W-1:0] i_cfg_wdata,
    output logic                    o_valid,
    output logic                    o_hit,
    output logic                    o_writeback_valid,
    output logic      [ADDR_W-1:0]  o_writeback_addr,
    output logic                    o_refill_valid,
    output logic      [ADDR_W-1:0]  o_refill_addr,
    output logic                    o_line_cleaned
);

    logic                accept;
    logic [SHIFT_W-1:0]  r_shift;
    t_split              split;
    logic [SHIFT_W-1:0]  eff_shift;

    logic                r_s1_vld;
    logic [REQ_W-1:0]    r_s1_req;
    logic [TAG_W-1:0]    r_s1_tag;
    logic [SET_W-1:0]    r_s1_set;
    logic [SHIFT_W-1:0]  r_s1_shift;

    logic [ROW_W-1:0]    ram_rdata;
    t_row                row_sel;
    t_row                row_new;
    t_result             res;

    logic [SETS-1:0]     r_init;
    logic                r_fwd_vld;
    logic [SET_W-1:0]    r_fwd_set;
    t_row                r_fwd_row;

    logic                r_out_vld;
    t_result             r_res;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            r_shift <= i_cfg_wdata;
        end
    end

    sacft_split u_split (
        .i_address (i_address),
        .i_shift   (r_shift),
        .o_split   (split),
        .o_shift   (eff_shift)
    );

    sacft_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_set),
        .i_wdata (row_new),
        .i_re    (accept),
        .i_raddr (split.set_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
        if (accept) begin
            r_s1_req   <= i_req_type;
            r_s1_tag   <= split.tag;
            r_s1_set   <= split.set_idx;
            r_s1_shift <= eff_shift;
        end
    end

    always_comb begin
        if (r_fwd_vld && (r_fwd_set == r_s1_set)) begin
            row_sel = r_fwd_row;
        end else begin
            row_sel = t_row'(ram_rdata);
        end
        // untouched set: no valid way, pointer starts at way 0
        if (!r_init[r_s1_set]) begin
            row_sel.vptr  = '0;
            row_sel.valid = '0;
        end
    end

    sacft_update u_update (
        .i_req   (r_s1_req),
        .i_tag   (r_s1_tag),
        .i_shift (r_s1_shift),
        .i_row   (row_sel),
        .o_row   (row_new),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_fwd_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_s1_vld) begin
                r_init[r_s1_set] <= 1'b1;
            end
            r_fwd_vld <= r_s1_vld;
            r_out_vld <= r_s1_vld;
        end
        r_fwd_set <= r_s1_set;
        r_fwd_row <= row_new;
        r_res     <= res;
    end

    assign o_valid           = r_out_vld;
    assign o_hit             = r_res.hit;
    assign o_writeback_valid = r_res.wb_valid;
    assign o_writeback_addr  = r_res.wb_addr;
    assign o_refill_valid    = r_res.rf_valid;
    assign o_refill_addr     = r_res.rf_addr;
    assign o_line_cleaned    = r_res.cleaned;

endmodule
`default_nettype wire

>>> sv/sacft_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sacft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/sacft_split.sv
// Line-shift clamp and split of a byte address into set index and tag.
`default_nettype none
module sacft_split
    import sacft_pkg::*;
(
    input  wire logic [ADDR_W-1:0]  i_address,
    input  wire logic [SHIFT_W-1:0] i_shift,
    output t_split                  o_split,
    output logic      [SHIFT_W-1:0] o_shift
);

    logic [ADDR_W-1:0] line;

    always_comb begin
        priority if (i_shift < SHIFT_MIN) begin
            o_shift = SHIFT_MIN;
        end else if (i_shift > SHIFT_MAX) begin
            o_shift = SHIFT_MAX;
        end else begin
            o_shift = i_shift;
        end
        line            = i_address >> o_shift;
        o_split.tag     = line[TAG_W-1:0];
        o_split.set_idx = line[SET_W-1:0] & SET_MASK;
    end

endmodule
`default_nettype wire

>>> sv/sacft_update.sv
// Way compare, replacement and maintenance decisions for one set.
`default_nettype none
module sacft_update
    import sacft_pkg::*;
(
    input  wire logic [REQ_W-1:0]   i_req,
    input  wire logic [TAG_W-1:0]   i_tag,
    input  wire logic [SHIFT_W-1:0] i_shift,
    input  wire t_row               i_row,
    output t_row                    o_row,
    output t_result                 o_res
);

    logic             hit_any;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] slot;

    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        // descending so the lowest matching way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_row.valid[w] && (i_row.ways[w].tag == i_tag)) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        slot = i_row.vptr;
        if (int'(slot) >= WAYS) begin
            slot = '0;
        end

        o_row   = i_row;
        o_res   = '0;

        priority if ((i_req == REQ_READ) || (i_req == REQ_WRITE)) begin
            if (hit_any) begin
                o_res.hit = 1'b1;
                if (i_req == REQ_WRITE) begin
                    o_row.ways[hit_way].dirty = 1'b1;
                end
            end else begin
                if (i_row.valid[slot] && i_row.ways[slot].dirty) begin
                    o_res.wb_valid = 1'b1;
                    o_res.wb_addr  = line_to_addr(i_row.ways[slot].tag, i_shift);
                end
                o_row.ways[slot].tag   = i_tag;
                o_row.ways[slot].dirty = (i_req == REQ_WRITE);
                o_row.valid[slot]      = 1'b1;
                o_row.vptr = (int'(slot) + 1 >= WAYS) ? '0 : slot + 1'b1;
                o_res.rf_valid = 1'b1;
                o_res.rf_addr  = line_to_addr(i_tag, i_shift);
            end
        end else if (((i_req == REQ_CLEAN) || (i_req == REQ_INV) || (i_req == REQ_CINV))
                     && hit_any) begin
            o_res.hit = 1'b1;
            if (((i_req == REQ_CLEAN) || (i_req == REQ_CINV)) && i_row.ways[hit_way].dirty) begin
                o_row.ways[hit_way].dirty = 1'b0;
                o_res.cleaned             = 1'b1;
            end
            if ((i_req == REQ_INV) || (i_req == REQ_CINV)) begin
                o_row.valid[hit_way] = 1'b0;
            end
        end else begin
            o_res = '0;
        end
    end

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the FIFO-replacement cache tag store.
`timescale 1ns / 100ps
module tb_top
    import sacft_pkg::*;
();

    localparam logic [REQ_W-1:0] REQ_SPARE5 = REQ_W'(5);
    localparam logic [REQ_W-1:0] REQ_SPARE6 = REQ_W'(6);
    localparam logic [REQ_W-1:0] REQ_SPARE7 = REQ_W'(7);
    localparam int DIR_N = 25;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 137;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        logic              chk;
        t_result           res;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [REQ_W-1:0]   i_req_type = '0;
    logic [ADDR_W-1:0]  i_address = '0;
    logic               i_cfg_we = 1'b0;
    logic [SHIFT_W-1:0] i_cfg_wdata = '0;
    logic               o_valid;
    logic               o_hit;
    logic               o_writeback_valid;
    logic [ADDR_W-1:0]  o_writeback_addr;
    logic               o_refill_valid;
    logic [ADDR_W-1:0]  o_refill_addr;
    logic               o_line_cleaned;

    // typed expectation travels with the request
    logic    drv_chk = 1'b0;
    t_result drv_exp = '0;

    // model state of the tag store
    logic [TAG_W-1:0]   tag_mem   [SETS*WAYS];
    logic               tag_valid [SETS*WAYS];
    logic               tag_dirty [SETS*WAYS];
    logic [WAY_W-1:0]   fill_ptr  [SETS];
    logic [SHIFT_W-1:0] shift_cfg;

    t_result pending_results [$];
    int      fail_cnt = 0;
    int      n_sent = 0;
    int      n_hits = 0;
    int      n_refills = 0;
    int      n_wbs = 0;
    int      n_cleans = 0;

    t_dir_row dir_tab [DIR_N] = '{
        '{REQ_READ,   64'h0,    1'b1, '{1'b0, 1'b0, 64'h0, 1'b1, 64'h0, 1'b0}},
        '{REQ_READ,   64'h3F,   1'b1, '{1'b1, 1'b0, 64'h0, 1'b0, 64'h0, 1'b0}},
        '{REQ_WRITE,  64'h8,    1'b1, '{1'b1, 1'b0, 64'h0, 1'b0, 64'h0, 1'b0}},
        '{REQ_CLEAN,  64'h10,   1'b1, '{1'b1, 1'b0, 64'h0, 1'b0, 64'h0, 1'b1}},
        '{REQ_CLEAN,  64'h0,    1'b1, '{1'b1, 1'b0, 64'h0, 1'b0, 64'h0, 1'b0}},
        '{REQ_READ,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{1'b0, 1'b0, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFC0, 1'b0}},
        '{REQ_WRITE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{1'b1, 1'b0, 64'h0, 1'b0, 64'h0, 1'b0}},
        '{REQ_CINV,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{1'b1, 1'b0, 64'h0, 1'b0, 64'h0, 1'b1}},
        '{REQ_INV,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
        '{REQ_CINV,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
        '{REQ_SPARE5, 64'h0,    1'b1, '0},
        '{REQ_SPARE6, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '0},
        '{REQ_SPARE7, 64'h5555_5555_5555_5555, 1'b1, '0},
        '{REQ_READ,   64'h0,    1'b1, '{1'b1, 1'b0, 64'h0, 1'b0, 64'h0, 1'b0}},
        '{REQ_WRITE,  64'h7000, 1'b1, '{1'b0, 1'b0, 64'h0, 1'b1, 64'h7000, 1'b0}},
        '{REQ_INV,    64'h7000, 1'b1, '{1'b1, 1'b0, 64'h0, 1'b0, 64'h0, 1'b0}},
        '{REQ_WRITE,  64'h1000, 1'b0, '0},
        '{REQ_WRITE,  64'h2000, 1'b0, '0},
        '{REQ_WRITE,  64'h3000, 1'b0, '0},
        '{REQ_READ,   64'h4000, 1'b0, '0},
        '{REQ_READ,   64'h5000, 1'b0, '0},
        '{REQ_READ,   64'h2010, 1'b0, '0},
        '{REQ_CLEAN,  64'h2000, 1'b0, '0},
        '{REQ_READ,   64'h6000, 1'b0, '0},
        '{REQ_WRITE,  64'h8000_0000_0000_0000, 1'b0, '0}
    };

    set_assoc_cache_fifo_tags dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_address         (i_address),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_valid           (o_valid),
        .o_hit             (o_hit),
        .o_writeback_valid (o_writeback_valid),
        .o_writeback_addr  (o_writeback_addr),
        .o_refill_valid    (o_refill_valid),
        .o_refill_addr     (o_refill_addr),
        .o_line_cleaned    (o_line_cleaned)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 200000);
        $display("Timeout waiting for the tag store");
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] v);
        if (v < SHIFT_MIN) return SHIFT_MIN;
        if (v > SHIFT_MAX) return SHIFT_MAX;
        return v;
    endfunction

    // tag lookup and update for one transaction
    function automatic t_result predict_lookup(input logic [REQ_W-1:0] req,
                                               input logic [ADDR_W-1:0] addr);
        t_result           r;
        logic [SHIFT_W-1:0] sh;
        logic [ADDR_W-1:0] ln;
        logic [TAG_W-1:0]  tg;
        int                st;
        int                base;
        int                w;
        int                slot;
        int                e;
        r = '0;
        sh = clamp_shift(shift_cfg);
        ln = addr >> sh;
        tg = ln[TAG_W-1:0];
        st = int'(ln[SET_W-1:0] & SET_MASK);
        base = st * WAYS;
        w = -1;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (tag_valid[base+i] && tag_mem[base+i] == tg) w = i;
        end
        case (req)
            REQ_READ, REQ_WRITE: begin
                if (w >= 0) begin
                    r.hit = 1'b1;
                    if (req == REQ_WRITE) tag_dirty[base+w] = 1'b1;
                end else begin
                    slot = int'(fill_ptr[st]);
                    e = base + slot;
                    if (tag_valid[e] && tag_dirty[e]) begin
                        r.wb_valid = 1'b1;
                        r.wb_addr = {{(ADDR_W-TAG_W){1'b0}}, tag_mem[e]} << sh;
                    end
                    tag_mem[e] = tg;
                    tag_valid[e] = 1'b1;
                    tag_dirty[e] = (req == REQ_WRITE);
                    fill_ptr[st] = (slot + 1 >= WAYS) ? '0 : WAY_W'(slot + 1);
                    r.rf_valid = 1'b1;
                    r.rf_addr = addr & ~((64'd1 << sh) - 64'd1);
                end
            end
            REQ_CLEAN, REQ_INV, REQ_CINV: begin
                if (w >= 0) begin
                    r.hit = 1'b1;
                    if (req != REQ_INV && tag_dirty[base+w]) begin
                        tag_dirty[base+w] = 1'b0;
                        r.cleaned = 1'b1;
                    end
                    if (req != REQ_CLEAN) tag_valid[base+w] = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // accepted transactions and register writes, sampled at the edge
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n) begin
            if (i_cfg_we) shift_cfg = i_cfg_wdata;
            if (start && busy == 1'b0) begin
                r = predict_lookup(i_req_type, i_address);
                if (drv_chk) r = drv_exp;
                pending_results.push_back(r);
                n_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result act;
        t_result exp_r;
        if (i_rst_n && o_valid === 1'b1) begin
            act = '{o_hit, o_writeback_valid, o_writeback_addr, o_refill_valid,
                    o_refill_addr, o_line_cleaned};
            if (pending_results.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("Unexpected result: hit=%0b wb=%0b/%h rf=%0b/%h cln=%0b",
                             act.hit, act.wb_valid, act.wb_addr, act.rf_valid,
                             act.rf_addr, act.cleaned);
            end else begin
                exp_r = pending_results.pop_front();
                if (act.hit !== exp_r.hit || act.wb_valid !== exp_r.wb_valid ||
                    act.wb_addr !== exp_r.wb_addr || act.rf_valid !== exp_r.rf_valid ||
                    act.rf_addr !== exp_r.rf_addr || act.cleaned !== exp_r.cleaned) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS) begin
                        $display("Mismatch exp: hit=%0b wb=%0b/%h rf=%0b/%h cln=%0b",
                                 exp_r.hit, exp_r.wb_valid, exp_r.wb_addr,
                                 exp_r.rf_valid, exp_r.rf_addr, exp_r.cleaned);
                        $display("         act: hit=%0b wb=%0b/%h rf=%0b/%h cln=%0b",
                                 act.hit, act.wb_valid, act.wb_addr, act.rf_valid,
                                 act.rf_addr, act.cleaned);
                    end
                end
            end
            n_hits    += act.hit;
            n_refills += act.rf_valid;
            n_wbs     += act.wb_valid;
            n_cleans  += act.cleaned;
        end
    end

    // called right after a rising edge; returns after the accept and idle gaps
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                                input logic chk, input t_result exp_r, input int idle_pct);
        bit free;
        start      <= 1'b1;
        i_req_type <= req;
        i_address  <= addr;
        drv_chk    <= chk;
        drv_exp    <= exp_r;
        do begin
            @(negedge i_clk);
            free = (busy == 1'b0);
            @(posedge i_clk);
        end while (!free);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_shift(input logic [SHIFT_W-1:0] v);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [SHIFT_W-1:0] plan [PHASES];
        logic [SHIFT_W-1:0] eff;
        logic [SHIFT_W-1:0] sh_gen;
        logic [ADDR_W-1:0]  hi_line;
        logic [ADDR_W-1:0]  ln;
        logic [ADDR_W-1:0]  addr;
        logic [REQ_W-1:0]   req;
        int                 set_base;
        int                 pct;
        int                 r;
        int                 guard;
        plan = '{4'd6, 4'd3, 4'd12, 4'd0, 4'd15, 4'd9, 4'd2, 4'd13, 4'd6};
        for (int i = 0; i < SETS * WAYS; i++) begin
            tag_mem[i]   = '0;
            tag_valid[i] = 1'b0;
            tag_dirty[i] = 1'b0;
        end
        for (int i = 0; i < SETS; i++) fill_ptr[i] = '0;
        shift_cfg = SHIFT_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_N; k++)
            send_request(dir_tab[k].req, dir_tab[k].addr, dir_tab[k].chk, dir_tab[k].res, 0);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1) plan[ph] = SHIFT_W'($urandom_range(15));
            if (ph > 0) write_shift(plan[ph]);
            eff = clamp_shift(plan[ph]);
            hi_line = (ph % 3 == 0) ? '0 : ({$urandom, $urandom} & ~64'hFFF);
            set_base = $urandom_range(SETS - 4);
            case (ph % 3)
                0: pct = 0;
                1: pct = 75;
                default: pct = 19;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(99);
                if (r < 35) req = REQ_READ;
                else if (r < 60) req = REQ_WRITE;
                else if (r < 72) req = REQ_CLEAN;
                else if (r < 82) req = REQ_INV;
                else if (r < 94) req = REQ_CINV;
                else req = REQ_W'($urandom_range(5, 7));

                sh_gen = ($urandom_range(99) < 70) ? eff : SHIFT_W'($urandom_range(3, 12));
                r = $urandom_range(99);
                if (r < 12) begin
                    addr = {$urandom, $urandom};
                end else if (r < 18) begin
                    case ($urandom_range(2))
                        0: ln = '0;
                        1: ln = '1;
                        default: ln = 64'd1 << (63 - sh_gen);
                    endcase
                    addr = (ln << sh_gen) | ({$urandom, $urandom} & ((64'd1 << sh_gen) - 1));
                end else begin
                    // few tags over few sets: hits, fills and evictions
                    ln = hi_line | (64'($urandom_range(5)) << SET_W)
                         | 64'(set_base + $urandom_range(3));
                    addr = (ln << sh_gen) | ({$urandom, $urandom} & ((64'd1 << sh_gen) - 1));
                end
                send_request(req, addr, 1'b0, '0, (n % 64 < 16) ? 0 : pct);
            end
        end
        start <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (6) @(posedge i_clk);
        fail_cnt += pending_results.size();

        $display("Sent %0d transactions over %0d line-size settings, %0d failures.",
                 n_sent, PHASES, fail_cnt);
        $display("Results: %0d hits, %0d refills, %0d writebacks, %0d lines cleaned.",
                 n_hits, n_refills, n_wbs, n_cleans);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/sacft_pkg.sv
sv/sacft_ram.sv
sv/sacft_split.sv
sv/sacft_update.sv
sv/set_assoc_cache_fifo_tags.sv
tb/sv/tb_top.sv
